// ===== src/tmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmsp_pkg
// Types and codes shared by the step-script parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmsp_pkg;

	// line phases
	localparam logic [3:0] PH_LEAD        = 4'd0;
	localparam logic [3:0] PH_KEYWORD     = 4'd1;
	localparam logic [3:0] PH_SETTLE_GAP  = 4'd2;
	localparam logic [3:0] PH_SETTLE_NUM  = 4'd3;
	localparam logic [3:0] PH_SETTLE_TAIL = 4'd4;
	localparam logic [3:0] PH_TIME_NUM    = 4'd5;
	localparam logic [3:0] PH_MASK_GAP    = 4'd6;
	localparam logic [3:0] PH_MASK_NUM    = 4'd7;
	localparam logic [3:0] PH_MASK_TAIL   = 4'd8;
	localparam logic [3:0] PH_IGNORE      = 4'd9;

	// number token stages
	localparam logic [2:0] TK_WS   = 3'd0;
	localparam logic [2:0] TK_SIGN = 3'd1;
	localparam logic [2:0] TK_ZERO = 3'd2;
	localparam logic [2:0] TK_HEX0 = 3'd3;
	localparam logic [2:0] TK_DIG  = 3'd4;

	// number base
	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_OCT = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	// error codes
	localparam logic [2:0] E_LONG   = 3'd0;
	localparam logic [2:0] E_RANGE  = 3'd1;
	localparam logic [2:0] E_SETTLE = 3'd2;
	localparam logic [2:0] E_SYNTAX = 3'd3;
	localparam logic [2:0] E_MASK   = 3'd4;
	localparam logic [2:0] E_MONO   = 3'd5;
	localparam logic [2:0] E_MANY   = 3'd6;

	// result kinds
	localparam logic [1:0] KIND_STEP = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_NL = 8'h0a;

	typedef struct packed {
		logic [3:0]  phase;
		logic [2:0]  kw_idx;
		logic [31:0] acc;
		logic        ovf;
		logic [1:0]  base;
		logic [31:0] held;
		logic        err_pend;
		logic [2:0]  err_code;
		logic [2:0]  tok;
		logic        neg;
	} line_st_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] step_time_ms;
		logic [31:0] step_mask;
		logic [31:0] settle_time_ms;
		logic [8:0]  step_count;
		logic [2:0]  error_code;
		logic [15:0] line_number;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

// ===== src/tmsp_char_step.sv =====
// ----------------------------------------------------------------------------
// tmsp_char_step
// Per-character line scanner: next line state for one byte or the line end.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsp_char_step (
	input  wire tmsp_pkg::line_st_t st,
	input  wire logic [7:0]         ch,
	input  wire logic               line_end,
	output tmsp_pkg::line_st_t      st_nx
);

	localparam logic [1:0] TR_MORE  = 2'd0;
	localparam logic [1:0] TR_OK    = 2'd1;
	localparam logic [1:0] TR_NONE  = 2'd2;
	localparam logic [1:0] TR_RANGE = 2'd3;

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		d = 5'd16;
		if (c >= "0" && c <= "9") d = 5'(c - "0");
		else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
		return d;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] i);
		logic [7:0] k;
		unique case (i)
			3'd0: k = "s";
			3'd1: k = "e";
			3'd2: k = "t";
			3'd3: k = "t";
			3'd4: k = "l";
			default: k = "e";
		endcase
		return k;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0d;
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c == "+" || c == "-";
	endfunction

	function automatic tmsp_pkg::line_st_t set_err(input tmsp_pkg::line_st_t s,
			input logic [2:0] code);
		tmsp_pkg::line_st_t o;
		o = s;
		if (!o.err_pend) begin
			o.err_pend = 1'b1;
			o.err_code = code;
		end
		o.phase = tmsp_pkg::PH_IGNORE;
		return o;
	endfunction

	function automatic tmsp_pkg::line_st_t begin_tok(input tmsp_pkg::line_st_t s,
			input logic [3:0] nxt);
		tmsp_pkg::line_st_t o;
		o       = s;
		o.acc   = '0;
		o.ovf   = 1'b0;
		o.base  = tmsp_pkg::BASE_DEC;
		o.tok   = tmsp_pkg::TK_WS;
		o.neg   = 1'b0;
		o.phase = nxt;
		return o;
	endfunction

	function automatic logic [1:0] tok_feed(input tmsp_pkg::line_st_t s, input logic [7:0] c,
			input logic b0, input logic e, output tmsp_pkg::line_st_t o);
		logic [4:0]  d;
		logic        go;
		logic [1:0]  r;
		logic [4:0]  radix;
		logic [35:0] t;
		o  = s;
		d  = e ? 5'd16 : digit_of(c);
		go = 1'b1;
		r  = TR_MORE;
		if (o.tok == tmsp_pkg::TK_WS) begin
			if (!e && (is_blank(c) || c == 8'h0b || c == 8'h0c)) begin
				go = 1'b0;
			end else if (!e && is_sign(c)) begin
				o.neg = (c == "-");
				o.tok = tmsp_pkg::TK_SIGN;
				go    = 1'b0;
			end else begin
				o.tok = tmsp_pkg::TK_SIGN;
			end
		end
		if (go && o.tok == tmsp_pkg::TK_SIGN) begin
			if (b0 && !e && c == "0") begin
				o.tok = tmsp_pkg::TK_ZERO;
			end else if (d < 5'd10) begin
				o.acc  = 32'(d);
				o.base = tmsp_pkg::BASE_DEC;
				o.tok  = tmsp_pkg::TK_DIG;
			end else begin
				r = TR_NONE;
			end
		end else if (go && o.tok == tmsp_pkg::TK_ZERO) begin
			if (!e && (c == "x" || c == "X")) begin
				o.tok = tmsp_pkg::TK_HEX0;
			end else if (d < 5'd8) begin
				o.acc  = 32'(d);
				o.base = tmsp_pkg::BASE_OCT;
				o.tok  = tmsp_pkg::TK_DIG;
			end else begin
				r = TR_OK;
			end
		end else if (go && o.tok == tmsp_pkg::TK_HEX0) begin
			if (d < 5'd16) begin
				o.acc  = 32'(d);
				o.base = tmsp_pkg::BASE_HEX;
				o.tok  = tmsp_pkg::TK_DIG;
			end else begin
				r = TR_NONE;
			end
		end else if (go) begin
			radix = (o.base == tmsp_pkg::BASE_OCT) ? 5'd8 :
				((o.base == tmsp_pkg::BASE_HEX) ? 5'd16 : 5'd10);
			if (d < radix) begin
				unique case (o.base)
					tmsp_pkg::BASE_OCT: t = {1'b0, o.acc, 3'b000};
					tmsp_pkg::BASE_HEX: t = {o.acc, 4'b0000};
					default:            t = {1'b0, o.acc, 3'b000} + {3'b000, o.acc, 1'b0};
				endcase
				t = t + 36'(d);
				if (t[35:32] != 4'd0) o.ovf = 1'b1;
				o.acc = t[31:0];
			end else if (o.ovf || (o.neg && o.acc != 32'd0)) begin
				r = TR_RANGE;
			end else begin
				r = TR_OK;
			end
		end
		return r;
	endfunction

	always_comb begin
		tmsp_pkg::line_st_t s;
		tmsp_pkg::line_st_t f;
		logic [1:0] r;
		logic       done;
		s    = st;
		f    = st;
		r    = TR_MORE;
		done = 1'b0;
		// a phase can hand the same character on; three hand-offs at most
		for (int it = 0; it < 4; it++) begin
			if (!done) begin
				done = 1'b1;
				unique case (s.phase)
					tmsp_pkg::PH_LEAD: begin
						if (line_end || is_blank(ch)) begin
						end else if (ch == "#") begin
							s.phase = tmsp_pkg::PH_IGNORE;
						end else if (ch == "s") begin
							s.phase  = tmsp_pkg::PH_KEYWORD;
							s.kw_idx = 3'd1;
						end else if (is_sign(ch)) begin
							s = set_err(s, tmsp_pkg::E_SYNTAX);
						end else begin
							s    = begin_tok(s, tmsp_pkg::PH_TIME_NUM);
							done = 1'b0;
						end
					end
					tmsp_pkg::PH_KEYWORD: begin
						if (s.kw_idx < 3'd6) begin
							if (!line_end && ch == kw_char(s.kw_idx)) s.kw_idx = s.kw_idx + 3'd1;
							else s = set_err(s, tmsp_pkg::E_SYNTAX);
						end else if (line_end) begin
							s = set_err(s, tmsp_pkg::E_SETTLE);
						end else if (ch == " " || ch == 8'h09) begin
							s.phase = tmsp_pkg::PH_SETTLE_GAP;
						end else begin
							s = set_err(s, tmsp_pkg::E_SYNTAX);
						end
					end
					tmsp_pkg::PH_SETTLE_GAP: begin
						if (line_end) begin
							s = set_err(s, tmsp_pkg::E_SETTLE);
						end else if (is_blank(ch)) begin
						end else if (is_sign(ch)) begin
							s = set_err(s, tmsp_pkg::E_SETTLE);
						end else begin
							s    = begin_tok(s, tmsp_pkg::PH_SETTLE_NUM);
							done = 1'b0;
						end
					end
					tmsp_pkg::PH_SETTLE_NUM: begin
						r = tok_feed(s, ch, 1'b0, line_end, f);
						s = f;
						priority case (r)
							TR_RANGE: s = set_err(s, tmsp_pkg::E_RANGE);
							TR_NONE:  s = set_err(s, tmsp_pkg::E_SETTLE);
							TR_OK: begin
								s.phase = tmsp_pkg::PH_SETTLE_TAIL;
								done    = 1'b0;
							end
							default: ;
						endcase
					end
					tmsp_pkg::PH_SETTLE_TAIL: begin
						if (!(line_end || is_blank(ch))) s = set_err(s, tmsp_pkg::E_SETTLE);
					end
					tmsp_pkg::PH_TIME_NUM: begin
						r = tok_feed(s, ch, 1'b0, line_end, f);
						s = f;
						priority case (r)
							TR_RANGE: s = set_err(s, tmsp_pkg::E_RANGE);
							TR_NONE:  s = set_err(s, tmsp_pkg::E_SYNTAX);
							TR_OK: begin
								s.held  = s.acc;
								s.phase = tmsp_pkg::PH_MASK_GAP;
								done    = 1'b0;
							end
							default: ;
						endcase
					end
					tmsp_pkg::PH_MASK_GAP: begin
						if (line_end) begin
							s = set_err(s, tmsp_pkg::E_SYNTAX);
						end else if (is_blank(ch)) begin
						end else if (is_sign(ch)) begin
							s = set_err(s, tmsp_pkg::E_SYNTAX);
						end else begin
							s    = begin_tok(s, tmsp_pkg::PH_MASK_NUM);
							done = 1'b0;
						end
					end
					tmsp_pkg::PH_MASK_NUM: begin
						r = tok_feed(s, ch, 1'b1, line_end, f);
						s = f;
						priority case (r)
							TR_RANGE: s = set_err(s, tmsp_pkg::E_RANGE);
							TR_NONE:  s = set_err(s, tmsp_pkg::E_SYNTAX);
							TR_OK: begin
								s.phase = tmsp_pkg::PH_MASK_TAIL;
								done    = 1'b0;
							end
							default: ;
						endcase
					end
					tmsp_pkg::PH_MASK_TAIL: begin
						if (!(line_end || is_blank(ch))) s = set_err(s, tmsp_pkg::E_SYNTAX);
					end
					default: ;
				endcase
			end
		end
		st_nx = s;
	end

endmodule

`default_nettype wire

// ===== src/tmsp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tmsp_out_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module tmsp_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_n,
	input  wire tmsp_pkg::result_t  push_a,
	input  wire tmsp_pkg::result_t  push_b,
	output logic                    room2,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tmsp_pkg::result_t       out_data,
	output logic [2:0]              count
);

	tmsp_pkg::result_t mem_q [4];
	logic [1:0] wptr_q, rptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_data  = mem_q[rptr_q];
	assign room2     = cnt_q <= 3'd2;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wptr_q] <= push_a;
		if (push_n == 2'd2) mem_q[wptr_q + 2'd1] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + push_n;
			if (pop) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + 3'(push_n) - 3'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== src/timed_mask_script_parser.sv =====
// ----------------------------------------------------------------------------
// timed_mask_script_parser
// Step-script text parser: byte stream in, step / completion / error out.
// ----------------------------------------------------------------------------
// One script byte is taken per cycle while s_tready is high and scanned
// combinationally; the results it causes (at most two, at end of text) go
// into a four-entry output queue, and s_tready stays high while that queue
// has room for two, so with m_tready held high the block runs at one byte
// per clock. After the completion or error result (m_tlast high) all
// further bytes are accepted and dropped until reset. mask_limit sits at
// byte address 0.
`default_nettype none

module timed_mask_script_parser #(
	parameter int MAX_STEPS  = 256,
	parameter int LINE_LIMIT = 160
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] text_byte
	input  wire logic         s_tlast,   // end_of_text
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] step_time_ms, [63:32] step_mask, [95:64] settle_time_ms,
	// [104:96] step_count, [107:105] error_code, [123:108] line_number
	output logic [127:0]      m_tdata,
	output logic [1:0]        m_tuser,   // [1:0] kind
	output logic              m_tlast,   // last
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SW = $clog2(MAX_STEPS + 1);

	tmsp_pkg::line_st_t st_q, st_nx, st_in, st_fin;
	logic [7:0]    len_q;
	logic [15:0]   line_cnt_q;
	logic          have_prev_q;
	logic [31:0]   prev_time_q;
	logic [SW-1:0] steps_q;
	logic [31:0]   settle_q;
	logic          stopped_q;
	logic [31:0]   mask_limit_q;

	logic          accept, eot, is_nl, fin;
	logic [15:0]   ln;
	logic [1:0]    push_n;
	tmsp_pkg::result_t res_a, res_b, out_r;
	logic          room2;
	logic [2:0]    fifo_cnt;
	logic [SW+8:0] steps_ext, steps_inc_ext;
	logic          fin_err, fin_step, settle_upd;
	logic [2:0]    fin_code;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? mask_limit_q : 32'd0;
	assign s_tready = room2;
	assign accept   = s_tvalid && s_tready;
	assign eot      = s_tlast || s_tdata == 8'd0;
	assign is_nl    = s_tdata == tmsp_pkg::CH_NL;
	assign fin      = eot ? (len_q != 8'd0) : is_nl;

	assign st_in = st_q;
	tmsp_char_step u_step (
		.st       (st_in),
		.ch       (s_tdata),
		.line_end (fin),
		.st_nx    (st_nx)
	);

	assign ln            = (line_cnt_q != 16'hffff) ? line_cnt_q + 16'd1 : 16'hffff;
	assign steps_ext     = {9'd0, steps_q};
	assign steps_inc_ext = {9'd0, steps_q + SW'(1)};

	always_comb begin
		fin_err  = 1'b0;
		fin_step = 1'b0;
		fin_code = tmsp_pkg::E_LONG;
		if (len_q >= 8'(LINE_LIMIT)) begin
			fin_err = 1'b1;
		end else if (st_nx.err_pend) begin
			fin_err  = 1'b1;
			fin_code = st_nx.err_code;
		end else if (st_nx.phase == tmsp_pkg::PH_MASK_TAIL) begin
			if (st_nx.acc > mask_limit_q) begin
				fin_err  = 1'b1;
				fin_code = tmsp_pkg::E_MASK;
			end else if (have_prev_q && st_nx.held < prev_time_q) begin
				fin_err  = 1'b1;
				fin_code = tmsp_pkg::E_MONO;
			end else if (steps_q >= SW'(MAX_STEPS)) begin
				fin_err  = 1'b1;
				fin_code = tmsp_pkg::E_MANY;
			end else begin
				fin_step = 1'b1;
			end
		end
	end

	// settle line closing cleanly: new value also goes out with the completion
	assign settle_upd = fin && !fin_err && st_nx.phase == tmsp_pkg::PH_SETTLE_TAIL;

	always_comb begin
		st_fin          = st_nx;
		st_fin.phase    = tmsp_pkg::PH_LEAD;
		st_fin.kw_idx   = 3'd0;
		st_fin.err_pend = 1'b0;
	end

	always_comb begin
		tmsp_pkg::result_t fr, dn;
		fr = '0;
		if (fin_err) begin
			fr.kind        = tmsp_pkg::KIND_ERR;
			fr.step_count  = steps_ext[8:0];
			fr.error_code  = fin_code;
			fr.line_number = ln;
			fr.last        = 1'b1;
		end else begin
			fr.kind         = tmsp_pkg::KIND_STEP;
			fr.step_time_ms = st_nx.held;
			fr.step_mask    = st_nx.acc;
			fr.step_count   = steps_inc_ext[8:0];
		end
		dn                = '0;
		dn.kind           = tmsp_pkg::KIND_DONE;
		dn.settle_time_ms = settle_upd ? st_nx.acc : settle_q;
		dn.step_count     = fin_step ? steps_inc_ext[8:0] : steps_ext[8:0];
		dn.last           = 1'b1;
		push_n = 2'd0;
		res_a  = fr;
		res_b  = dn;
		if (accept && !stopped_q) begin
			if (fin && (fin_err || fin_step)) begin
				push_n = (eot && !fin_err) ? 2'd2 : 2'd1;
			end else if (eot) begin
				res_a  = dn;
				push_n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_limit_q <= 32'd65535;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			mask_limit_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			len_q       <= '0;
			line_cnt_q  <= '0;
			have_prev_q <= 1'b0;
			prev_time_q <= '0;
			steps_q     <= '0;
			settle_q    <= '0;
			stopped_q   <= 1'b0;
		end else if (accept && !stopped_q) begin
			if (fin) begin
				st_q       <= st_fin;
				len_q      <= '0;
				line_cnt_q <= ln;
				if (settle_upd) begin
					settle_q <= st_nx.acc;
				end
				if (fin_step) begin
					have_prev_q <= 1'b1;
					prev_time_q <= st_nx.held;
					steps_q     <= steps_q + SW'(1);
				end
				if (fin_err || eot) stopped_q <= 1'b1;
			end else if (eot) begin
				stopped_q <= 1'b1;
			end else begin
				st_q <= st_nx;
				if (len_q != 8'hff) len_q <= len_q + 8'd1;
			end
		end
	end

	tmsp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_a    (res_a),
		.push_b    (res_b),
		.room2     (room2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_r),
		.count     (fifo_cnt)
	);

	assign m_tuser = out_r.kind;
	assign m_tlast = out_r.last;
	assign m_tdata = {4'd0, out_r.line_number, out_r.error_code, out_r.step_count,
		out_r.settle_time_ms, out_r.step_mask, out_r.step_time_ms};

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt <= 3'd4)
		else $error("result queue overfilled");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop flag cleared without reset");

	a_no_push_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> push_n == 2'd0)
		else $error("result produced after run ended");

	a_last_means_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> stopped_q)
		else $error("final result without stop");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for timed_mask_script_parser. A byte-level predictor of
// the script parser runs on every accepted item and queues the step,
// completion and error results it expects. A monitor checks each result
// against that queue, field by field. The script opens with directed lines,
// then mask_limit changes between phases and random well-formed lines follow.
// One ending (end of text, zero byte or a faulty line) stops the run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_STEPS  = 256;
	localparam int LINE_LIMIT = 160;
	localparam int CYCLE_LIMIT = 400000;

	localparam int FEED_MORE  = 0;
	localparam int FEED_OK    = 1;
	localparam int FEED_NONE  = 2;
	localparam int FEED_RANGE = 3;

	localparam logic [2:0] MASK_LIMIT_ADDR = 3'd0;

	typedef struct {
		bit [7:0] ch;
		bit       eot;
	} text_item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = 3'd0;
	logic [31:0]  pwdata = 32'd0;
	logic [31:0]  prdata;
	logic         pready;

	timed_mask_script_parser #(
		.MAX_STEPS(MAX_STEPS),
		.LINE_LIMIT(LINE_LIMIT)
	) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	text_item_t         text_q[$];
	tmsp_pkg::result_t  expected_q[$];
	int                 errors = 0;
	int                 cyc = 0;
	bit                 calm;

	assign calm = (cyc >= 2000) && (cyc < 3500);

	// ---------------- parser predictor ----------------
	logic [31:0] lim;
	logic [3:0]  ph;
	int          kwi;
	int          llen;
	int unsigned lcnt;
	logic [31:0] acc;
	bit          ovf;
	logic [1:0]  nbase;
	logic [31:0] held;
	int          perr;   // 0 none, else code + 1
	bit          havep;
	logic [31:0] prevt;
	int          nsteps;
	logic [31:0] settle;
	bit          stopped;
	logic [2:0]  tstage;
	bit          tneg;
	string       kw = "settle";

	function automatic bit is_blank(bit [7:0] c);
		return c == " " || c == "\t" || c == 8'd13;
	endfunction

	function automatic bit is_cspace(bit [7:0] c);
		return is_blank(c) || c == 8'd11 || c == 8'd12;
	endfunction

	function automatic int digit_val(bit [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return 16;
	endfunction

	function automatic void hold_err(logic [2:0] code);
		if (perr == 0) perr = code + 1;
		ph = tmsp_pkg::PH_IGNORE;
	endfunction

	function automatic int feed_num(bit [7:0] c, bit base0, bit fin);
		int d;
		int radix;
		logic [63:0] t;
		d = fin ? 16 : digit_val(c);
		if (tstage == tmsp_pkg::TK_WS) begin
			if (!fin && is_cspace(c)) return FEED_MORE;
			if (!fin && (c == "+" || c == "-")) begin
				tneg = (c == "-");
				tstage = tmsp_pkg::TK_SIGN;
				return FEED_MORE;
			end
			tstage = tmsp_pkg::TK_SIGN;
		end
		if (tstage == tmsp_pkg::TK_SIGN) begin
			if (base0 && !fin && c == "0") begin
				tstage = tmsp_pkg::TK_ZERO;
				return FEED_MORE;
			end
			if (d < 10) begin
				acc = d; nbase = tmsp_pkg::BASE_DEC; tstage = tmsp_pkg::TK_DIG;
				return FEED_MORE;
			end
			return FEED_NONE;
		end
		if (tstage == tmsp_pkg::TK_ZERO) begin
			if (!fin && (c == "x" || c == "X")) begin
				tstage = tmsp_pkg::TK_HEX0;
				return FEED_MORE;
			end
			if (d < 8) begin
				acc = d; nbase = tmsp_pkg::BASE_OCT; tstage = tmsp_pkg::TK_DIG;
				return FEED_MORE;
			end
			return FEED_OK;
		end
		if (tstage == tmsp_pkg::TK_HEX0) begin
			if (d < 16) begin
				acc = d; nbase = tmsp_pkg::BASE_HEX; tstage = tmsp_pkg::TK_DIG;
				return FEED_MORE;
			end
			return FEED_NONE;
		end
		radix = nbase == tmsp_pkg::BASE_OCT ? 8 : (nbase == tmsp_pkg::BASE_HEX ? 16 : 10);
		if (d < radix) begin
			t = {32'd0, acc} * radix + d;
			if (t > 64'hFFFF_FFFF) ovf = 1'b1;
			acc = t[31:0];
			return FEED_MORE;
		end
		if (ovf || (tneg && acc != 0)) return FEED_RANGE;
		return FEED_OK;
	endfunction

	function automatic bit open_num(bit [7:0] c, logic [3:0] nxt, logic [2:0] sign_err);
		if (c == "+" || c == "-") begin
			hold_err(sign_err);
			return 1'b0;
		end
		acc = 0; ovf = 0; nbase = tmsp_pkg::BASE_DEC; tstage = tmsp_pkg::TK_WS; tneg = 0;
		ph = nxt;
		return 1'b1;
	endfunction

	function automatic void scan_char(bit [7:0] c, bit fin);
		int r;
		bit done;
		done = 1'b0;
		while (!done) begin
			done = 1'b1;
			case (ph)
				tmsp_pkg::PH_LEAD: begin
					if (!(fin || is_blank(c))) begin
						if (c == "#") ph = tmsp_pkg::PH_IGNORE;
						else if (c == "s") begin
							ph = tmsp_pkg::PH_KEYWORD;
							kwi = 1;
						end else if (open_num(c, tmsp_pkg::PH_TIME_NUM, tmsp_pkg::E_SYNTAX))
							done = 1'b0;
					end
				end
				tmsp_pkg::PH_KEYWORD: begin
					if (kwi < 6) begin
						if (!fin && c == kw[kwi]) kwi++;
						else hold_err(tmsp_pkg::E_SYNTAX);
					end else if (fin) hold_err(tmsp_pkg::E_SETTLE);
					else if (c == " " || c == "\t") ph = tmsp_pkg::PH_SETTLE_GAP;
					else hold_err(tmsp_pkg::E_SYNTAX);
				end
				tmsp_pkg::PH_SETTLE_GAP: begin
					if (fin) hold_err(tmsp_pkg::E_SETTLE);
					else if (!is_blank(c)) begin
						if (open_num(c, tmsp_pkg::PH_SETTLE_NUM, tmsp_pkg::E_SETTLE))
							done = 1'b0;
					end
				end
				tmsp_pkg::PH_SETTLE_NUM: begin
					r = feed_num(c, 1'b0, fin);
					if (r == FEED_RANGE) hold_err(tmsp_pkg::E_RANGE);
					else if (r == FEED_NONE) hold_err(tmsp_pkg::E_SETTLE);
					else if (r == FEED_OK) begin
						ph = tmsp_pkg::PH_SETTLE_TAIL;
						done = 1'b0;
					end
				end
				tmsp_pkg::PH_SETTLE_TAIL: begin
					if (!(fin || is_blank(c))) hold_err(tmsp_pkg::E_SETTLE);
				end
				tmsp_pkg::PH_TIME_NUM: begin
					r = feed_num(c, 1'b0, fin);
					if (r == FEED_RANGE) hold_err(tmsp_pkg::E_RANGE);
					else if (r == FEED_NONE) hold_err(tmsp_pkg::E_SYNTAX);
					else if (r == FEED_OK) begin
						held = acc;
						ph = tmsp_pkg::PH_MASK_GAP;
						done = 1'b0;
					end
				end
				tmsp_pkg::PH_MASK_GAP: begin
					if (fin) hold_err(tmsp_pkg::E_SYNTAX);
					else if (!is_blank(c)) begin
						if (open_num(c, tmsp_pkg::PH_MASK_NUM, tmsp_pkg::E_SYNTAX))
							done = 1'b0;
					end
				end
				tmsp_pkg::PH_MASK_NUM: begin
					r = feed_num(c, 1'b1, fin);
					if (r == FEED_RANGE) hold_err(tmsp_pkg::E_RANGE);
					else if (r == FEED_NONE) hold_err(tmsp_pkg::E_SYNTAX);
					else if (r == FEED_OK) begin
						ph = tmsp_pkg::PH_MASK_TAIL;
						done = 1'b0;
					end
				end
				tmsp_pkg::PH_MASK_TAIL: begin
					if (!(fin || is_blank(c))) hold_err(tmsp_pkg::E_SYNTAX);
				end
				default: ;
			endcase
		end
	endfunction

	function automatic tmsp_pkg::result_t make_result(logic [1:0] kind);
		tmsp_pkg::result_t r;
		r = '0;
		r.kind = kind;
		r.step_count = nsteps[8:0];
		return r;
	endfunction

	function automatic void close_line();
		int unsigned ln;
		int err;
		tmsp_pkg::result_t r;
		ln = lcnt < 65535 ? lcnt + 1 : 65535;
		lcnt = ln;
		err = 0;
		if (llen >= LINE_LIMIT) err = tmsp_pkg::E_LONG + 1;
		else begin
			scan_char(8'd0, 1'b1);
			if (perr != 0) err = perr;
			else if (ph == tmsp_pkg::PH_SETTLE_TAIL) settle = acc;
			else if (ph == tmsp_pkg::PH_MASK_TAIL) begin
				if (acc > lim) err = tmsp_pkg::E_MASK + 1;
				else if (havep && held < prevt) err = tmsp_pkg::E_MONO + 1;
				else if (nsteps >= MAX_STEPS) err = tmsp_pkg::E_MANY + 1;
				else begin
					havep = 1'b1;
					prevt = held;
					nsteps++;
					r = make_result(tmsp_pkg::KIND_STEP);
					r.step_time_ms = held;
					r.step_mask = acc;
					expected_q.push_back(r);
				end
			end
		end
		if (err != 0) begin
			r = make_result(tmsp_pkg::KIND_ERR);
			r.error_code = err - 1;
			r.line_number = ln[15:0];
			r.last = 1'b1;
			expected_q.push_back(r);
			stopped = 1'b1;
		end
		ph = tmsp_pkg::PH_LEAD;
		kwi = 0;
		llen = 0;
		perr = 0;
	endfunction

	function automatic void take_byte(bit [7:0] c, bit eot_in);
		tmsp_pkg::result_t r;
		if (stopped) return;
		if (eot_in || c == 8'd0) begin
			if (llen > 0) close_line();
			if (stopped) return;
			r = make_result(tmsp_pkg::KIND_DONE);
			r.settle_time_ms = settle;
			r.last = 1'b1;
			expected_q.push_back(r);
			stopped = 1'b1;
		end else if (c == 8'h0a) close_line();
		else begin
			if (llen < 255) llen++;
			scan_char(c, 1'b0);
		end
	endfunction

	initial begin
		lim = 32'hFFFF; ph = tmsp_pkg::PH_LEAD; kwi = 0; llen = 0; lcnt = 0; acc = 0;
		ovf = 0; nbase = tmsp_pkg::BASE_DEC; held = 0; perr = 0; havep = 0; prevt = 0;
		nsteps = 0; settle = 0; stopped = 0; tstage = tmsp_pkg::TK_WS; tneg = 0;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		text_item_t it;
		bit busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				take_byte(s_tdata, s_tlast);
				busy = 1'b0;
			end
			if (!busy) begin
				if (text_q.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
					it = text_q.pop_front();
					s_tdata <= it.ch;
					s_tlast <= it.eot;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		tmsp_pkg::result_t want;
		if (arst_n) begin
			cyc <= cyc + 1;
			m_tready <= calm || ($urandom_range(0, 99) >= 23);
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: kind %0d data %h last %0d",
							m_tuser, m_tdata, m_tlast);
				end else begin
					want = expected_q.pop_front();
					if (m_tuser != want.kind || m_tdata[31:0] != want.step_time_ms
						|| m_tdata[63:32] != want.step_mask
						|| m_tdata[95:64] != want.settle_time_ms
						|| m_tdata[104:96] != want.step_count
						|| m_tdata[107:105] != want.error_code
						|| m_tdata[123:108] != want.line_number
						|| m_tdata[127:124] != 4'd0 || m_tlast != want.last) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: exp kind %0d t %0d m %h st %0d n %0d e %0d",
								" ln %0d last %0d / got kind %0d t %0d m %h st %0d n %0d",
								" e %0d ln %0d last %0d"},
								want.kind, want.step_time_ms, want.step_mask,
								want.settle_time_ms, want.step_count, want.error_code,
								want.line_number, want.last, m_tuser, m_tdata[31:0],
								m_tdata[63:32], m_tdata[95:64], m_tdata[104:96],
								m_tdata[107:105], m_tdata[123:108], m_tlast);
					end
				end
			end
			if (cyc > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---------------- stimulus ----------------
	int unsigned gen_time = 10;
	int          gen_steps = 8;

	task automatic put_text(string s);
		text_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.ch = s[i];
			it.eot = 1'b0;
			text_q.push_back(it);
		end
	endtask

	task automatic put_end(bit [7:0] c, bit e);
		text_item_t it;
		it.ch = c;
		it.eot = e;
		text_q.push_back(it);
	endtask

	function automatic string blanks(int lo, int hi, bit with_cr);
		string s;
		string pick;
		int n;
		s = "";
		n = $urandom_range(lo, hi);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, with_cr ? 2 : 1))
				0: pick = " ";
				1: pick = "\t";
				default: pick = "\r";
			endcase
			s = {s, pick};
		end
		return s;
	endfunction

	function automatic string mask_text(logic [31:0] v);
		string h;
		h = $sformatf("%0h", v);
		case ($urandom_range(0, 3))
			0: return $sformatf("%0d", v);
			1: return {"0x", h};
			2: return {"0X", h.toupper()};
			default: return $sformatf("0%0o", v);
		endcase
	endfunction

	function automatic string step_line();
		string s;
		logic [31:0] m;
		gen_time += $urandom_range(0, 1000);
		m = (lim == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, lim);
		gen_steps++;
		s = blanks(0, 2, 1'b1);
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 1) != 0) s = {s, "\v +"};
			else s = {s, "\v "};
		end
		return {s, $sformatf("%0d", gen_time), blanks(1, 3, 1'b1), mask_text(m),
			blanks(0, 2, 1'b1), "\n"};
	endfunction

	task automatic random_line();
		string s;
		byte unsigned b;
		int k;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			s = {blanks(0, 3, 1'b1), "#"};
			repeat ($urandom_range(0, 40)) begin
				b = $urandom_range(1, 255);
				if (b == 8'h0a) b = 8'hff;
				s = {s, string'(b)};
			end
			put_text({s, "\n"});
		end else if (k < 16) begin
			put_text({blanks(0, 5, 1'b1), "\n"});
		end else if (k < 24 || gen_steps >= MAX_STEPS - 4) begin
			s = ($urandom_range(0, 3) == 0) ? "\f-0" : $sformatf("%0d", $urandom);
			put_text({blanks(0, 2, 1'b1), "settle", blanks(1, 3, 1'b0), s,
				blanks(0, 2, 1'b1), "\n"});
		end else begin
			put_text(step_line());
		end
	endtask

	task automatic drain();
		wait (text_q.size() == 0 && !s_tvalid);
		wait (expected_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; paddr <= MASK_LIMIT_ADDR; pwdata <= v; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		lim = v;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic put_fault();
		string s;
		case ($urandom_range(0, 8))
			0: begin
				s = "#";
				repeat (LINE_LIMIT) s = {s, "a"};
			end
			1: s = $sformatf("%0d 99999999999", gen_time);
			2: s = "settle x";
			3: s = "sett";
			4: s = "+5 1";
			5: s = $sformatf("%0d 0x", gen_time);
			6: s = $sformatf("%0d %0d", gen_time, {1'b0, lim} + 1);
			7: s = "0 1";
			default: s = $sformatf("%0d 1 z", gen_time);
		endcase
		if (s == "0 1" && gen_time == 0) s = "settle";
		put_text(s);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: skipped lines, settle extremes, every mask notation
		put_text("# comment line\n \t\r\n\nsettle 0\nsettle\t4294967295 \n");
		put_text("\v -0 0x0\n0 0\n1 65535\n2\t0xFFFF\n3 0177\n3 0X7f\n4 00\n");
		put_text("5 0\n\f+6 7\r\n");
		write_limit(32'hFFFF_FFFF);
		put_text("7 0xffffffff\n8 037777777777\n9 4294967295\n");
		write_limit(32'd0);
		put_text("10 0\n10 00\n");

		// random phases, limit changed at each phase boundary
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_limit(32'hFFFF);
				1: write_limit(32'hFFFF_FFFF);
				2: write_limit(32'd1);
				default: write_limit($urandom);
			endcase
			for (int n = text_q.size(); n < 295; n = text_q.size()) random_line();
		end
		wait (text_q.size() == 0);

		case ($urandom_range(0, 5))
			0: put_end(8'h41, 1'b1);
			1: put_end(8'd0, 1'b0);
			2: begin
				put_text(step_line());
				void'(text_q.pop_back());
				put_end($urandom_range(0, 255), 1'b1);
			end
			3: begin
				put_text("settle 42 ");
				put_end(8'd0, 1'b0);
			end
			4: begin
				put_fault();
				put_text("\n");
			end
			default: begin
				put_fault();
				put_end(8'h0a, 1'b1);
			end
		endcase
		// ignored once the run has stopped
		repeat (12) put_end($urandom_range(0, 255), $urandom_range(0, 1));

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== timed_mask_script_parser.f =====
src/tmsp_pkg.sv
src/tmsp_char_step.sv
src/tmsp_out_fifo.sv
src/timed_mask_script_parser.sv
dv/testbench.sv
